// File: src/wlsc_pkg.sv
// Shared types, constants and helper functions for the wrapped line segment clipper.
// Depends on nothing; every other file of the block refers to it by scoped names.
package wlsc_pkg;

  // Fixed-point format and sizes.
  localparam int FRAC_BITS   = 16;
  localparam int MAX_REPEATS = 7;
  localparam int IW          = 20;                  // integer copy coordinate width
  localparam int CW          = FRAC_BITS + IW + 2;  // fixed-point coordinate width
  localparam int MW          = CW - 1;              // operand magnitude width
  localparam int ML          = (MW + 1) / 2;        // low half of a split operand
  localparam int MH          = MW - ML;             // high half of a split operand
  localparam int PW          = 2 * MW;              // product width
  localparam int QW          = MW;                  // quotient width
  localparam int DCW         = $clog2(QW);          // step counter width
  localparam int KW          = $clog2(2 * MAX_REPEATS + 2);
  localparam int PASS_LIMIT  = 8;

  localparam logic [12:0] FRAME_MAX = 13'd4096;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_WORLD_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_REPEAT_LEFT  = 3'd3;
  localparam logic [2:0] CFG_REPEAT_RIGHT = 3'd4;

  // Outcode bit positions.
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [11:0]       clip_start_x;
    logic [11:0]       clip_start_y;
    logic [11:0]       clip_end_x;
    logic [11:0]       clip_end_y;
    logic signed [3:0] copy_shift;
    logic              last;
  } out_item_t;

  // Clip window as seen by the datapath.
  typedef struct packed {
    coord_t      xmax;
    coord_t      ymax;
    logic        empty;
    logic [14:0] world_width;
  } geom_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              start_copy;
    logic              setup;
    logic              mul_step;
    logic [1:0]        mul_idx;
    logic              div_init;
    logic              div_step;
    logic              update;
    logic              emit;
    logic              acc;
    logic              last;
    logic signed [3:0] shift;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic both_in;  // both endpoints inside the window
    logic trivial;  // both endpoints outside the same edge
  } stat_t;

  // Cohen-Sutherland outcode of one point.
  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t xmax, coord_t ymax);
    logic [3:0] c;
    c = '0;
    if (x < 0) c[OC_LEFT] = 1'b1;
    else if (x > xmax) c[OC_RIGHT] = 1'b1;
    if (y < 0) c[OC_BOTTOM] = 1'b1;
    else if (y > ymax) c[OC_TOP] = 1'b1;
    return c;
  endfunction

endpackage

// File: src/wlsc_ctrl.sv
// Controller state machine of the clipper: sequences copies, clip passes,
// the split multiply and the restoring divide. Depends on wlsc_pkg.
module wlsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_free,
  input  logic [2:0]         repeat_left,
  input  logic [2:0]         repeat_right,
  input  wlsc_pkg::stat_t    stat,
  output wlsc_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_COPY, S_TEST, S_MUL, S_DINIT, S_DIV, S_UPD, S_EMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [wlsc_pkg::KW-1:0]      k_r, k_nxt;
  logic [3:0]                   pass_r, pass_nxt;
  logic [wlsc_pkg::DCW-1:0]     cnt_r, cnt_nxt;
  logic                         acc_r, acc_nxt;
  logic signed [3:0]            shift;
  logic                         last;

  // Copy order: original, then left copies, then right copies.
  always_comb begin
    if (k_r == '0) begin
      shift = 4'sd0;
    end else if (k_r <= wlsc_pkg::KW'(repeat_left)) begin
      shift = 4'(4'd0 - 4'(k_r));
    end else begin
      shift = 4'(4'(k_r) - {1'b0, repeat_left});
    end
    last = (k_r == wlsc_pkg::KW'(repeat_left) + wlsc_pkg::KW'(repeat_right));
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    cmd       = '0;
    cmd.shift = shift;
    cmd.last  = last;
    cmd.acc   = acc_r;
    cmd.mul_idx = cnt_r[1:0];
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.start_copy = 1'b1;
        pass_nxt       = '0;
        state_nxt      = S_TEST;
      end
      S_TEST: begin
        if (stat.empty) begin
          acc_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else if (stat.both_in) begin
          acc_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.trivial || pass_r == 4'(wlsc_pkg::PASS_LIMIT)) begin
          acc_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          cmd.setup = 1'b1;
          pass_nxt  = pass_r + 4'd1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == wlsc_pkg::DCW'(wlsc_pkg::QW - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_TEST;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_COPY;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      pass_r  <= '0;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// File: src/wlsc_dp.sv
// Datapath of the clipper: endpoint registers, outcodes, edge setup,
// split multiplier, restoring divider and endpoint update. Depends on wlsc_pkg.
module wlsc_dp (
  input  logic                clk,
  input  wlsc_pkg::in_item_t  in_data,
  input  wlsc_pkg::geom_t     geom,
  input  wlsc_pkg::cmd_t      cmd,
  output wlsc_pkg::stat_t     stat,
  output wlsc_pkg::out_item_t res
);

  typedef enum logic [1:0] {E_TOP, E_BOTTOM, E_RIGHT, E_LEFT} edge_sel_t;

  wlsc_pkg::in_item_t          base_r;
  wlsc_pkg::coord_t            p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [3:0]           shift_r;
  logic [wlsc_pkg::MW-1:0]     am_r, em_r, dm_r;
  logic                        neg_r, dz_r, use0_r;
  wlsc_pkg::coord_t            v0_r;
  edge_sel_t                   edge_r;
  logic [wlsc_pkg::PW-1:0]     prod_r;
  logic [wlsc_pkg::MW-1:0]     rem_r;
  logic [wlsc_pkg::QW-1:0]     lo_r, q_r;

  logic [3:0]                  c0, c1, co;
  logic signed [wlsc_pkg::IW-1:0] off, cx0, cx1;
  wlsc_pkg::coord_t            sa, se, sd, sv0, dx, dy;
  edge_sel_t                   sedge;
  logic [wlsc_pkg::ML-1:0]     op_a, op_e;
  logic [2*wlsc_pkg::ML-1:0]   pp;
  logic [wlsc_pkg::PW-1:0]     pp_sh;
  logic [wlsc_pkg::MW:0]       dtry;
  logic                        dge;
  wlsc_pkg::coord_t            rq, val, nx, ny;

  // Outcodes of the current endpoints.
  always_comb begin
    c0 = wlsc_pkg::outcode(p0x_r, p0y_r, geom.xmax, geom.ymax);
    c1 = wlsc_pkg::outcode(p1x_r, p1y_r, geom.xmax, geom.ymax);
    stat.empty   = geom.empty;
    stat.both_in = ((c0 | c1) == 4'd0);
    stat.trivial = ((c0 & c1) != 4'd0);
  end

  // Copy placement: integer endpoints shifted by the world width.
  always_comb begin
    off = wlsc_pkg::IW'(cmd.shift) * wlsc_pkg::IW'($signed({1'b0, geom.world_width}));
    cx0 = wlsc_pkg::IW'(base_r.start_x) + off;
    cx1 = wlsc_pkg::IW'(base_r.end_x) + off;
  end

  // Edge selection and operands for the intersection.
  always_comb begin
    co  = (c0 != 4'd0) ? c0 : c1;
    dx  = p1x_r - p0x_r;
    dy  = p1y_r - p0y_r;
    if (co[wlsc_pkg::OC_TOP]) begin
      sa = dx; se = geom.ymax - p0y_r; sd = dy; sv0 = p0x_r; sedge = E_TOP;
    end else if (co[wlsc_pkg::OC_BOTTOM]) begin
      sa = dx; se = -p0y_r; sd = dy; sv0 = p0x_r; sedge = E_BOTTOM;
    end else if (co[wlsc_pkg::OC_RIGHT]) begin
      sa = dy; se = geom.xmax - p0x_r; sd = dx; sv0 = p0y_r; sedge = E_RIGHT;
    end else begin
      sa = dy; se = -p0x_r; sd = dx; sv0 = p0y_r; sedge = E_LEFT;
    end
  end

  // One partial product of the split multiply.
  always_comb begin
    op_a = cmd.mul_idx[1] ? wlsc_pkg::ML'(am_r[wlsc_pkg::MW-1:wlsc_pkg::ML])
                          : am_r[wlsc_pkg::ML-1:0];
    op_e = cmd.mul_idx[0] ? wlsc_pkg::ML'(em_r[wlsc_pkg::MW-1:wlsc_pkg::ML])
                          : em_r[wlsc_pkg::ML-1:0];
    pp   = op_a * op_e;
    case (cmd.mul_idx)
      2'd0:    pp_sh = wlsc_pkg::PW'(pp);
      2'd3:    pp_sh = wlsc_pkg::PW'({pp, {(2 * wlsc_pkg::ML){1'b0}}});
      default: pp_sh = wlsc_pkg::PW'({pp, {wlsc_pkg::ML{1'b0}}});
    endcase
  end

  // One restoring divide step.
  always_comb begin
    dtry = {rem_r, lo_r[wlsc_pkg::QW-1]};
    dge  = (dtry >= {1'b0, dm_r});
  end

  // New endpoint from the quotient.
  always_comb begin
    if (dz_r) rq = '0;
    else if (neg_r) rq = -wlsc_pkg::CW'(q_r);
    else rq = wlsc_pkg::CW'(q_r);
    val = v0_r + rq;
    case (edge_r)
      E_TOP:    begin nx = val;       ny = geom.ymax; end
      E_BOTTOM: begin nx = val;       ny = '0;        end
      E_RIGHT:  begin nx = geom.xmax; ny = val;       end
      default:  begin nx = '0;        ny = val;       end
    endcase
  end

  // Result fields.
  always_comb begin
    res.accepted     = cmd.acc;
    res.clip_start_x = cmd.acc ? p0x_r[wlsc_pkg::FRAC_BITS +: 12] : 12'd0;
    res.clip_start_y = cmd.acc ? p0y_r[wlsc_pkg::FRAC_BITS +: 12] : 12'd0;
    res.clip_end_x   = cmd.acc ? p1x_r[wlsc_pkg::FRAC_BITS +: 12] : 12'd0;
    res.clip_end_y   = cmd.acc ? p1y_r[wlsc_pkg::FRAC_BITS +: 12] : 12'd0;
    res.copy_shift   = shift_r;
    res.last         = cmd.last;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) base_r <= in_data;
    if (cmd.start_copy) begin
      shift_r <= cmd.shift;
      p0x_r   <= {{2{cx0[wlsc_pkg::IW-1]}}, cx0, {wlsc_pkg::FRAC_BITS{1'b0}}};
      p0y_r   <= {{(wlsc_pkg::CW-16-wlsc_pkg::FRAC_BITS){base_r.start_y[15]}},
                  base_r.start_y, {wlsc_pkg::FRAC_BITS{1'b0}}};
      p1x_r   <= {{2{cx1[wlsc_pkg::IW-1]}}, cx1, {wlsc_pkg::FRAC_BITS{1'b0}}};
      p1y_r   <= {{(wlsc_pkg::CW-16-wlsc_pkg::FRAC_BITS){base_r.end_y[15]}},
                  base_r.end_y, {wlsc_pkg::FRAC_BITS{1'b0}}};
    end
    if (cmd.setup) begin
      am_r   <= wlsc_pkg::MW'(sa[wlsc_pkg::CW-1] ? -sa : sa);
      em_r   <= wlsc_pkg::MW'(se[wlsc_pkg::CW-1] ? -se : se);
      dm_r   <= wlsc_pkg::MW'(sd[wlsc_pkg::CW-1] ? -sd : sd);
      neg_r  <= sa[wlsc_pkg::CW-1] ^ se[wlsc_pkg::CW-1] ^ sd[wlsc_pkg::CW-1];
      dz_r   <= (sd == '0);
      v0_r   <= sv0;
      edge_r <= sedge;
      use0_r <= (c0 != 4'd0);
    end
    if (cmd.mul_step) begin
      prod_r <= ((cmd.mul_idx == 2'd0) ? '0 : prod_r) + pp_sh;
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[wlsc_pkg::PW-1:wlsc_pkg::QW];
      lo_r  <= prod_r[wlsc_pkg::QW-1:0];
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= dge ? wlsc_pkg::MW'(dtry - {1'b0, dm_r}) : dtry[wlsc_pkg::MW-1:0];
      lo_r  <= {lo_r[wlsc_pkg::QW-2:0], 1'b0};
      q_r   <= {q_r[wlsc_pkg::QW-2:0], dge};
    end
    if (cmd.update) begin
      if (use0_r) begin
        p0x_r <= nx;
        p0y_r <= ny;
      end else begin
        p1x_r <= nx;
        p1y_r <= ny;
      end
    end
  end

endmodule

// File: src/wrapped_line_segment_clipper.sv
// Top level of the wrapped line segment clipper: configuration registers,
// result register, controller and datapath. Depends on wlsc_pkg, wlsc_ctrl, wlsc_dp.
//
//   Channel  Ports                          Moves
//   input    in_valid, in_stall, in_data    one segment item
//   result   out_valid, out_stall, out_data one clipped copy item
//   config   cfg_we, cfg_idx, cfg_wdata     one register write
//
// One segment is worked on at a time; each copy makes at most PASS_LIMIT edge clips
// and may wait on an output stall. Each clip runs the split multiplier
// and then the one-bit-per-cycle restoring divider.
// An item yields 1 + left + right copies.
// Reset is synchronous; it clears control state and loads the default window.
// A result waits in the output register while out_stall is high; the next copy
// is computed meanwhile and held until the register frees.
module wrapped_line_segment_clipper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wlsc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wlsc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [14:0]          cfg_wdata
);

  logic [12:0]          frame_width_r, frame_height_r;
  logic [14:0]          world_width_r;
  logic [2:0]           repeat_left_r, repeat_right_r;
  logic [12:0]          fw_c, fh_c;
  wlsc_pkg::geom_t      geom;
  wlsc_pkg::cmd_t       cmd;
  wlsc_pkg::stat_t      stat;
  wlsc_pkg::out_item_t  res;
  logic                 out_valid_r;
  wlsc_pkg::out_item_t  out_data_r;
  logic                 out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd1024;
      frame_height_r <= 13'd512;
      world_width_r  <= 15'd1024;
      repeat_left_r  <= 3'd0;
      repeat_right_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        wlsc_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
        wlsc_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[12:0];
        wlsc_pkg::CFG_WORLD_WIDTH:  world_width_r  <= cfg_wdata;
        wlsc_pkg::CFG_REPEAT_LEFT:  repeat_left_r  <= cfg_wdata[2:0];
        wlsc_pkg::CFG_REPEAT_RIGHT: repeat_right_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Clip window edges in fixed point.
  always_comb begin
    fw_c = (frame_width_r > wlsc_pkg::FRAME_MAX) ? wlsc_pkg::FRAME_MAX : frame_width_r;
    fh_c = (frame_height_r > wlsc_pkg::FRAME_MAX) ? wlsc_pkg::FRAME_MAX : frame_height_r;
    geom.xmax        = wlsc_pkg::CW'({fw_c - 13'd1, {wlsc_pkg::FRAC_BITS{1'b0}}});
    geom.ymax        = wlsc_pkg::CW'({fh_c - 13'd1, {wlsc_pkg::FRAC_BITS{1'b0}}});
    geom.empty       = (fw_c == 13'd0) || (fh_c == 13'd0);
    geom.world_width = world_width_r;
  end

  assign out_free = !out_valid_r || !out_stall;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wlsc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_free     (out_free),
    .repeat_left  (repeat_left_r),
    .repeat_right (repeat_right_r),
    .stat         (stat),
    .cmd          (cmd)
  );

  wlsc_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .geom    (geom),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

endmodule

// File: src/wlsc_checker.sv
// Port-level checks for the wrapped line segment clipper, bound to its top level.
// Depends on wlsc_pkg and wrapped_line_segment_clipper.
module wlsc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input wlsc_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input wlsc_pkg::out_item_t  out_data,
  input logic                 cfg_we,
  input logic [2:0]           cfg_idx,
  input logic [14:0]          cfg_wdata
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // The block takes one segment at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // Register writes land only while the block is idle and carry known values.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_stall && !out_valid && !$isunknown({cfg_idx, cfg_wdata}))
    else $error("register write while busy");

  // A rejected copy carries zero endpoints.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.clip_start_x == 12'd0 && out_data.clip_start_y == 12'd0 &&
      out_data.clip_end_x == 12'd0 && out_data.clip_end_y == 12'd0)
    else $error("rejected copy with nonzero endpoints");

endmodule

bind wrapped_line_segment_clipper wlsc_checker u_wlsc_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the wrapped line segment clipper.
// Depends on wlsc_pkg and wrapped_line_segment_clipper.
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int N_DIRECTED   = 12;
  localparam int ITEMS_PER_SET = 30;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  wlsc_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_stall;
  wlsc_pkg::out_item_t  out_data;
  logic                 cfg_we;
  logic [2:0]           cfg_idx;
  logic [14:0]          cfg_wdata;

  wrapped_line_segment_clipper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the configuration registers.
  int unsigned win_w, win_h, wrap_w, n_left, n_right;

  wlsc_pkg::out_item_t copies_due[$];
  int        mismatches;
  int        results_seen;
  int        segments_sent;
  int        cycles = 0;
  int        in_gap_pct;
  int        out_gap_pct;

  typedef struct {
    wlsc_pkg::in_item_t  seg;
    bit                  typed;
    wlsc_pkg::out_item_t want;
  } row_t;
  row_t rows[N_DIRECTED];

  // Clock and cycle watchdog.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, copies_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] region(longint x, longint y, longint xmax, longint ymax);
    logic [3:0] c;
    c = '0;
    if (x < 0) c[wlsc_pkg::OC_LEFT] = 1'b1;
    else if (x > xmax) c[wlsc_pkg::OC_RIGHT] = 1'b1;
    if (y < 0) c[wlsc_pkg::OC_BOTTOM] = 1'b1;
    else if (y > ymax) c[wlsc_pkg::OC_TOP] = 1'b1;
    return c;
  endfunction

  // Exact a * b / c truncated toward zero; zero for a zero divisor.
  function automatic longint scaled_quot(longint a, longint b, longint c);
    logic signed [127:0] pa, pb, pc, q;
    if (c == 0) return 0;
    pa = a;
    pb = b;
    pc = c;
    q = (pa * pb) / pc;
    return longint'(q);
  endfunction

  // Clip one shifted copy of the segment against the window.
  function automatic wlsc_pkg::out_item_t clip_one(longint sx, longint sy, longint ex,
                                                   longint ey, int shift, bit is_last);
    longint one, fw, fh, xmax, ymax, x0, y0, x1, y1, x, y;
    logic [3:0] c0, c1, co;
    bit acc;
    wlsc_pkg::out_item_t r;
    one = longint'(1) << wlsc_pkg::FRAC_BITS;
    fw = (win_w > 4096) ? 4096 : win_w;
    fh = (win_h > 4096) ? 4096 : win_h;
    xmax = (fw - 1) * one;
    ymax = (fh - 1) * one;
    x0 = sx * one; y0 = sy * one; x1 = ex * one; y1 = ey * one;
    c0 = region(x0, y0, xmax, ymax);
    c1 = region(x1, y1, xmax, ymax);
    acc = 1'b0;
    for (int pass = 0; pass < 9 && fw > 0 && fh > 0; pass++) begin
      if ((c0 | c1) == 0) begin
        acc = 1'b1;
        break;
      end
      if ((c0 & c1) != 0 || pass == 8) break;
      co = (c0 != 0) ? c0 : c1;
      if (co[wlsc_pkg::OC_TOP]) begin
        x = x0 + scaled_quot(x1 - x0, ymax - y0, y1 - y0); y = ymax;
      end else if (co[wlsc_pkg::OC_BOTTOM]) begin
        x = x0 + scaled_quot(x1 - x0, -y0, y1 - y0); y = 0;
      end else if (co[wlsc_pkg::OC_RIGHT]) begin
        y = y0 + scaled_quot(y1 - y0, xmax - x0, x1 - x0); x = xmax;
      end else begin
        y = y0 + scaled_quot(y1 - y0, -x0, x1 - x0); x = 0;
      end
      if (co == c0) begin
        x0 = x; y0 = y; c0 = region(x0, y0, xmax, ymax);
      end else begin
        x1 = x; y1 = y; c1 = region(x1, y1, xmax, ymax);
      end
    end
    r = '0;
    r.accepted = acc;
    if (acc) begin
      r.clip_start_x = x0[27:16];
      r.clip_start_y = y0[27:16];
      r.clip_end_x   = x1[27:16];
      r.clip_end_y   = y1[27:16];
    end
    r.copy_shift = 4'(shift);
    r.last = is_last;
    return r;
  endfunction

  // Append one expected result item.
  function automatic void queue_expect(wlsc_pkg::out_item_t r);
    copies_due = {copies_due, r};
  endfunction

  // Queue the results of every wrapped copy of one segment, in output order.
  function automatic void predict_copies(wlsc_pkg::in_item_t s);
    int total, shift;
    total = 1 + n_left + n_right;
    for (int k = 0; k < total; k++) begin
      shift = (k == 0) ? 0 : (k <= n_left ? -k : k - n_left);
      queue_expect(clip_one(longint'(s.start_x) + shift * longint'(wrap_w),
                            longint'(s.start_y),
                            longint'(s.end_x) + shift * longint'(wrap_w),
                            longint'(s.end_y), shift, k == total - 1));
    end
  endfunction

  // Offer one segment; hold it until the block takes it.
  task automatic send_segment(wlsc_pkg::in_item_t s, bit typed, wlsc_pkg::out_item_t want);
    while (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data  = s;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (typed) queue_expect(want);
    else predict_copies(s);
    segments_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = 15'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      wlsc_pkg::CFG_FRAME_WIDTH:  win_w   = value & 32'h1FFF;
      wlsc_pkg::CFG_FRAME_HEIGHT: win_h   = value & 32'h1FFF;
      wlsc_pkg::CFG_WORLD_WIDTH:  wrap_w  = value & 32'h7FFF;
      wlsc_pkg::CFG_REPEAT_LEFT:  n_left  = value & 32'h7;
      wlsc_pkg::CFG_REPEAT_RIGHT: n_right = value & 32'h7;
      default: ;
    endcase
  endtask

  // Let the block drain, then load a full window setting.
  task automatic load_setting(int sel);
    while (copies_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    case (sel)
      0: begin
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 1024); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 512);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 1024); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 1);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 1);
      end
      1: begin
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 4096); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 4096);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 32767); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 7);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 7);
      end
      2: begin
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 1); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 1);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 1); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 2);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 0);
      end
      3: begin
        // Zero width leaves an empty window.
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 0); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 100);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 500); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 0);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 3);
      end
      4: begin
        // Oversized frame saturates, and all copies coincide.
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 8191); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 8191);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 0); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 3);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 3);
      end
      default: begin
        write_reg(wlsc_pkg::CFG_FRAME_WIDTH, 64); write_reg(wlsc_pkg::CFG_FRAME_HEIGHT, 48);
        write_reg(wlsc_pkg::CFG_WORLD_WIDTH, 100); write_reg(wlsc_pkg::CFG_REPEAT_LEFT, 2);
        write_reg(wlsc_pkg::CFG_REPEAT_RIGHT, 2);
      end
    endcase
  endtask

  function automatic logic [15:0] rand_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(1600)) - 300);
  endfunction

  // Result side: random stall, compare each item with the oldest expectation.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (out_gap_pct > 0) && ($urandom_range(99) < out_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (copies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %p", out_data);
      end else begin
        wlsc_pkg::out_item_t want;
        want = copies_due.pop_front();
        if (out_data.accepted !== want.accepted || out_data.clip_start_x !== want.clip_start_x
            || out_data.clip_start_y !== want.clip_start_y
            || out_data.clip_end_x !== want.clip_end_x
            || out_data.clip_end_y !== want.clip_end_y
            || out_data.copy_shift !== want.copy_shift || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  function automatic row_t mk(int sx, int sy, int ex, int ey, bit typed, bit acc,
                              int csx, int csy, int cex, int cey);
    row_t r;
    r.seg = '{start_x: 16'(sx), start_y: 16'(sy), end_x: 16'(ex), end_y: 16'(ey)};
    r.typed = typed;
    r.want = '{accepted: acc, clip_start_x: 12'(csx), clip_start_y: 12'(csy),
               clip_end_x: 12'(cex), clip_end_y: 12'(cey), copy_shift: 4'sd0, last: 1'b1};
    return r;
  endfunction

  initial begin
    wlsc_pkg::in_item_t s;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_idx = wlsc_pkg::CFG_FRAME_WIDTH; cfg_wdata = '0;
    mismatches = 0; results_seen = 0; segments_sent = 0;
    in_gap_pct = 36; out_gap_pct = 87;
    win_w = 1024; win_h = 512; wrap_w = 1024; n_left = 0; n_right = 0;

    // Directed segments under the reset window (1024 x 512, no copies).
    rows[0]  = mk(10, 20, 100, 200, 1, 1, 10, 20, 100, 200);
    rows[1]  = mk(-5, -5, -1, -10, 1, 0, 0, 0, 0, 0);
    rows[2]  = mk(-100, 10, 2000, 10, 1, 1, 0, 10, 1023, 10);
    rows[3]  = mk(5, -50, 5, 900, 1, 1, 5, 0, 5, 511);
    rows[4]  = mk(3, 3, 3, 3, 1, 1, 3, 3, 3, 3);
    rows[5]  = mk(1023, 511, 0, 0, 1, 1, 1023, 511, 0, 0);
    rows[6]  = mk(2000, 600, 3000, 900, 1, 0, 0, 0, 0, 0);
    rows[7]  = mk(-32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0);
    rows[8]  = mk(32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0);
    rows[9]  = mk(-300, 700, 1500, -200, 0, 0, 0, 0, 0, 0);
    rows[10] = mk(500, 600, 1100, 100, 0, 0, 0, 0, 0, 0);
    rows[11] = mk(-1, 256, 1024, 257, 0, 0, 0, 0, 0, 0);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].want);

    // Three idling regimes, each over three window settings.
    for (int ph = 0; ph < 3; ph++) begin
      in_gap_pct  = (ph == 0) ? 36 : (ph == 1) ? 87 : 0;
      out_gap_pct = (ph == 0) ? 87 : (ph == 1) ? 36 : 0;
      for (int j = 0; j < 3; j++) begin
        load_setting((ph * 3 + j) % 6);
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          bit wide;
          wide = ($urandom_range(9) < 4);
          s.start_x = rand_coord(wide);
          s.start_y = rand_coord(wide);
          s.end_x   = rand_coord(wide);
          s.end_y   = rand_coord(wide);
          send_segment(s, 1'b0, '0);
        end
      end
    end

    while (copies_due.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d segments over six window settings and three stall regimes;", segments_sent);
    $display("checked %0d clipped copies, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && copies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/wlsc_pkg.sv
src/wlsc_ctrl.sv
src/wlsc_dp.sv
src/wrapped_line_segment_clipper.sv
src/wlsc_checker.sv
tb/tb.sv
